// File: rtl/gais_pkg.sv
`default_nettype none

package gais_pkg;

    localparam int RATE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 25;
    localparam int N_AXES   = 3;
    localparam int AXIS_W   = 2;
    localparam int HIST_W   = N_AXES * ANGLE_W;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;

    localparam int WINDOW_DEFAULT = 6;

    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_YAW;

    localparam logic [PADDR_W-1:0] ADDR_SENSOR_PRESENT = 3'd0;

    // angle arithmetic in 27 bits signed
    localparam int WIDE_W = ANGLE_W + 2;
    localparam logic signed [WIDE_W-1:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [WIDE_W-1:0] FULL_TURN = 27'sd23592960;
    localparam logic [ANGLE_W:0] FULL_TURN_MAG = 26'd23592960;

    // |rate| * elapsed above this gives an increment beyond a full turn
    localparam logic [PROD_W-1:0] SAT_PROD_LIMIT = 64'd5760000;
    localparam int SAT_PROD_W  = 23;
    localparam int SCALE_SHIFT = 9;

    // x * 512 / 125 == (x * 512 * RECIP_125) >> 38, exact for 32-bit operands
    localparam logic [MUL_W-1:0] RECIP_125   = 32'd2199023256;
    localparam int               RECIP_SHIFT = 38;

    // ceil(2^32 / n), exact division for sums below 2^28
    localparam int MEAN_SHIFT = 32;
    localparam int RECIP_IDX_W = 5;
    localparam logic [MUL_W-1:0] MEAN_RECIP [0:16] = '{
        32'd0,          32'd0,          32'd2147483648, 32'd1431655766,
        32'd1073741824, 32'd858993460,  32'd715827883,  32'd613566757,
        32'd536870912,  32'd477218589,  32'd429496730,  32'd390451573,
        32'd357913942,  32'd330382100,  32'd306783379,  32'd286331154,
        32'd268435456
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_UPD,
        ST_PUSH,
        ST_SUM,
        ST_DIV1,
        ST_DIV2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } hist_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/gais_mul.sv
`default_nettype none

module gais_mul (
    input  wire logic                          clk,
    input  wire logic [gais_pkg::MUL_W-1:0]    a,
    input  wire logic [gais_pkg::MUL_W-1:0]    b,
    output logic      [gais_pkg::PROD_W-1:0]   prod
);

    logic [gais_pkg::PROD_W-1:0] prod_reg;
    logic [gais_pkg::PROD_W-1:0] prod_next;

    assign prod_next = gais_pkg::PROD_W'(a) * gais_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/gais_hist.sv
`default_nettype none

module gais_hist #(
    parameter int DEPTH = gais_pkg::WINDOW_DEFAULT,
    parameter int IDX_W = 3
) (
    input  wire logic                          clk,
    input  wire gais_pkg::hist_ctrl_t          ctrl,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [gais_pkg::HIST_W-1:0]   wr_data,
    input  wire logic [IDX_W-1:0]              rd_addr,
    output logic      [gais_pkg::HIST_W-1:0]   rd_data
);

    logic [gais_pkg::HIST_W-1:0] mem [DEPTH];
    logic [gais_pkg::HIST_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/gyro_angle_integrator_smoother.sv
`default_nettype none

// gyro angle integrator with a moving-average smoother
// requests come in on in_valid/in_ready: three signed Q12.4 rates, a ms timestamp and
// sample_ok. each request gives one result on out_valid/out_ready: the Q9.16 angles
// and the mean of the last WINDOW angle triples, truncated toward zero.
// sensor_present (apb, address 0) must be set or requests leave the state untouched.
// one 32x32 multiplier is shared by all multiplications under a small sequencer:
// per axis MUL1, MUL2 and UPD for the integration, PUSH to write the window,
// SUM to add up the window (one entry per cycle from the history memory),
// per axis DIV1 and DIV2 on the multiplier for the mean, and DONE to load the result.
// in_ready is high only while the sequencer is idle, so a new request is taken at the
// earliest in the cycle after the previous result is loaded, never while one is in work.
// a result waits in the output register while out_ready is low; the next request is
// still taken and processed, and waits before its own load until the output frees up.
// reset clears the angles, the timestamp, the started flag, the window fill and
// sensor_present; the first request with the sensor present latches its timestamp and
// leaves the angles at zero.

module gyro_angle_integrator_smoother #(
    parameter int WINDOW = gais_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [gais_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [gais_pkg::APB_DW-1:0]            pwdata,
    output logic      [gais_pkg::APB_DW-1:0]            prdata,
    output logic                                        pready,

    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [gais_pkg::RATE_W-1:0]     rate_roll,
    input  wire logic signed [gais_pkg::RATE_W-1:0]     rate_pitch,
    input  wire logic signed [gais_pkg::RATE_W-1:0]     rate_yaw,
    input  wire logic        [gais_pkg::TIME_W-1:0]     time_ms,
    input  wire logic                                   sample_ok,

    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [gais_pkg::ANGLE_W-1:0]         raw_roll,
    output logic signed [gais_pkg::ANGLE_W-1:0]         raw_pitch,
    output logic signed [gais_pkg::ANGLE_W-1:0]         raw_yaw,
    output logic signed [gais_pkg::ANGLE_W-1:0]         mean_roll,
    output logic signed [gais_pkg::ANGLE_W-1:0]         mean_pitch,
    output logic signed [gais_pkg::ANGLE_W-1:0]         mean_yaw
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = gais_pkg::ANGLE_W + CNT_W;

    gais_pkg::state_t state_reg;
    gais_pkg::state_t state_next;

    logic                                   sensor_present_reg;
    logic                                   started_reg;
    logic [gais_pkg::TIME_W-1:0]            last_time_reg;
    logic signed [gais_pkg::ANGLE_W-1:0]    angle_reg [gais_pkg::N_AXES];
    logic [CNT_W-1:0]                       fill_count_reg;
    logic [IDX_W-1:0]                       write_slot_reg;

    logic signed [gais_pkg::RATE_W-1:0]     rate_reg [gais_pkg::N_AXES];
    logic [gais_pkg::TIME_W-1:0]            elapsed_reg;
    logic [gais_pkg::AXIS_W-1:0]            axis_reg;
    logic                                   sat_reg;

    logic [CNT_W-1:0]                       idx_reg;
    logic                                   rdv_reg;
    logic signed [SUM_W-1:0]                sum_reg [gais_pkg::N_AXES];
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_reg [gais_pkg::N_AXES];

    logic                                   out_valid_reg;
    logic signed [gais_pkg::ANGLE_W-1:0]    raw_out_reg [gais_pkg::N_AXES];
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_out_reg [gais_pkg::N_AXES];

    logic                                   in_fire;
    logic                                   cfg_write;
    logic                                   out_free;

    logic [gais_pkg::MUL_W-1:0]             mul_a;
    logic [gais_pkg::MUL_W-1:0]             mul_b;
    logic [gais_pkg::PROD_W-1:0]            prod;

    gais_pkg::hist_ctrl_t                   hist_ctrl;
    logic [gais_pkg::HIST_W-1:0]            hist_wr_data;
    logic [gais_pkg::HIST_W-1:0]            hist_rd_data;

    logic signed [gais_pkg::RATE_W-1:0]     rate_cur;
    logic [gais_pkg::RATE_W-1:0]            rate_mag;
    logic [gais_pkg::ANGLE_W:0]             inc_mag;
    logic signed [gais_pkg::WIDE_W-1:0]     inc_s;
    logic signed [gais_pkg::WIDE_W-1:0]     ang_sum;
    logic signed [gais_pkg::ANGLE_W-1:0]    angle_next;

    logic signed [SUM_W-1:0]                sum_cur;
    logic [SUM_W-1:0]                       sum_mag;
    logic [gais_pkg::ANGLE_W-1:0]           quot;
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_next;

    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || out_ready;

    // apb register
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr == gais_pkg::ADDR_SENSOR_PRESENT)
        begin
            prdata = gais_pkg::APB_DW'(sensor_present_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg <= 1'b0;
        end
        else if (cfg_write && paddr == gais_pkg::ADDR_SENSOR_PRESENT)
        begin
            sensor_present_reg <= pwdata[0];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gais_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!sensor_present_reg)
                    begin
                        state_next = gais_pkg::ST_SUM;
                    end
                    else if (started_reg && sample_ok)
                    begin
                        state_next = gais_pkg::ST_MUL1;
                    end
                    else
                    begin
                        state_next = gais_pkg::ST_PUSH;
                    end
                end
            end
            gais_pkg::ST_MUL1: state_next = gais_pkg::ST_MUL2;
            gais_pkg::ST_MUL2: state_next = gais_pkg::ST_UPD;
            gais_pkg::ST_UPD:
            begin
                state_next = (axis_reg == gais_pkg::AXIS_LAST) ? gais_pkg::ST_PUSH
                                                               : gais_pkg::ST_MUL1;
            end
            gais_pkg::ST_PUSH: state_next = gais_pkg::ST_SUM;
            gais_pkg::ST_SUM:
            begin
                if (idx_reg == fill_count_reg)
                begin
                    state_next = gais_pkg::ST_DIV1;
                end
            end
            gais_pkg::ST_DIV1: state_next = gais_pkg::ST_DIV2;
            gais_pkg::ST_DIV2:
            begin
                state_next = (axis_reg == gais_pkg::AXIS_LAST) ? gais_pkg::ST_DONE
                                                               : gais_pkg::ST_DIV1;
            end
            gais_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = gais_pkg::ST_IDLE;
                end
            end
            default: state_next = gais_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        hist_ctrl.wr_en = 1'b0;
        hist_ctrl.rd_en = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (state_reg)
            gais_pkg::ST_IDLE: in_ready = 1'b1;
            gais_pkg::ST_MUL1:
            begin
                mul_a = gais_pkg::MUL_W'(rate_mag);
                mul_b = elapsed_reg;
            end
            gais_pkg::ST_MUL2:
            begin
                mul_a = {prod[gais_pkg::SAT_PROD_W-1:0], gais_pkg::SCALE_SHIFT'(0)};
                mul_b = gais_pkg::RECIP_125;
            end
            gais_pkg::ST_PUSH: hist_ctrl.wr_en = 1'b1;
            gais_pkg::ST_SUM:  hist_ctrl.rd_en = (idx_reg < fill_count_reg);
            gais_pkg::ST_DIV1:
            begin
                mul_a = gais_pkg::MUL_W'(sum_mag);
                mul_b = gais_pkg::MEAN_RECIP[gais_pkg::RECIP_IDX_W'(fill_count_reg)];
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    gais_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign hist_wr_data = {angle_reg[gais_pkg::AXIS_YAW],
                           angle_reg[gais_pkg::AXIS_PITCH],
                           angle_reg[gais_pkg::AXIS_ROLL]};

    gais_hist #(
        .DEPTH (WINDOW),
        .IDX_W (IDX_W)
    ) u_hist (
        .clk     (clk),
        .ctrl    (hist_ctrl),
        .wr_addr (write_slot_reg),
        .wr_data (hist_wr_data),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (hist_rd_data)
    );

    // integration step for the current axis, truncation toward zero via sign-magnitude
    assign rate_cur = rate_reg[axis_reg];
    assign rate_mag = rate_cur[gais_pkg::RATE_W-1] ? gais_pkg::RATE_W'(-rate_cur)
                                                   : gais_pkg::RATE_W'(rate_cur);
    assign inc_mag  = sat_reg ? gais_pkg::FULL_TURN_MAG
                              : prod[gais_pkg::PROD_W-1:gais_pkg::RECIP_SHIFT];
    assign inc_s    = rate_cur[gais_pkg::RATE_W-1] ? -$signed({1'b0, inc_mag})
                                                   : $signed({1'b0, inc_mag});
    assign ang_sum  = gais_pkg::WIDE_W'(angle_reg[axis_reg]) + inc_s;

    always_comb
    begin
        if (ang_sum < -gais_pkg::HALF_TURN)
        begin
            angle_next = gais_pkg::ANGLE_W'(ang_sum + gais_pkg::FULL_TURN);
        end
        else if (ang_sum > gais_pkg::HALF_TURN)
        begin
            angle_next = gais_pkg::ANGLE_W'(ang_sum - gais_pkg::FULL_TURN);
        end
        else
        begin
            angle_next = gais_pkg::ANGLE_W'(ang_sum);
        end
    end

    // mean for the current axis
    assign sum_cur = sum_reg[axis_reg];
    assign sum_mag = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
    assign quot    = prod[gais_pkg::MEAN_SHIFT +: gais_pkg::ANGLE_W];

    always_comb
    begin
        if (fill_count_reg == CNT_W'(0))
        begin
            mean_next = '0;
        end
        else if (fill_count_reg == CNT_W'(1))
        begin
            mean_next = gais_pkg::ANGLE_W'(sum_cur);
        end
        else if (sum_cur[SUM_W-1])
        begin
            mean_next = -$signed(quot);
        end
        else
        begin
            mean_next = $signed(quot);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gais_pkg::ST_IDLE;
            started_reg    <= 1'b0;
            last_time_reg  <= '0;
            for (int k = 0; k < gais_pkg::N_AXES; k++)
            begin
                angle_reg[k] <= '0;
            end
            fill_count_reg <= '0;
            write_slot_reg <= '0;
            axis_reg       <= gais_pkg::AXIS_ROLL;
            idx_reg        <= '0;
            rdv_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // angles stay zero until started, so the first request only marks the time
            if (in_fire && sensor_present_reg && (!started_reg || sample_ok))
            begin
                last_time_reg <= time_ms;
            end
            if (in_fire && sensor_present_reg)
            begin
                started_reg <= 1'b1;
            end

            if (state_reg == gais_pkg::ST_UPD)
            begin
                angle_reg[axis_reg] <= angle_next;
            end

            if (state_reg == gais_pkg::ST_UPD || state_reg == gais_pkg::ST_DIV2)
            begin
                axis_reg <= (axis_reg == gais_pkg::AXIS_LAST) ? gais_pkg::AXIS_ROLL
                                                              : axis_reg + 1'b1;
            end

            if (state_reg == gais_pkg::ST_PUSH)
            begin
                write_slot_reg <= (write_slot_reg == IDX_W'(WINDOW - 1)) ? '0
                                                                        : write_slot_reg + 1'b1;
                if (fill_count_reg != CNT_W'(WINDOW))
                begin
                    fill_count_reg <= fill_count_reg + 1'b1;
                end
            end

            if (state_reg == gais_pkg::ST_SUM)
            begin
                idx_reg <= idx_reg + 1'b1;
                rdv_reg <= (idx_reg < fill_count_reg);
            end
            else if (state_reg == gais_pkg::ST_IDLE || state_reg == gais_pkg::ST_PUSH)
            begin
                idx_reg <= '0;
                rdv_reg <= 1'b0;
            end

            if (state_reg == gais_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rate_reg[gais_pkg::AXIS_ROLL]  <= rate_roll;
            rate_reg[gais_pkg::AXIS_PITCH] <= rate_pitch;
            rate_reg[gais_pkg::AXIS_YAW]   <= rate_yaw;
            elapsed_reg                    <= time_ms - last_time_reg;
        end

        if (state_reg == gais_pkg::ST_MUL2)
        begin
            sat_reg <= (prod > gais_pkg::SAT_PROD_LIMIT);
        end

        if (state_reg == gais_pkg::ST_SUM)
        begin
            if (rdv_reg)
            begin
                for (int k = 0; k < gais_pkg::N_AXES; k++)
                begin
                    sum_reg[k] <= sum_reg[k]
                        + SUM_W'($signed(hist_rd_data[k*gais_pkg::ANGLE_W +: gais_pkg::ANGLE_W]));
                end
            end
        end
        else if (state_reg == gais_pkg::ST_IDLE || state_reg == gais_pkg::ST_PUSH)
        begin
            for (int k = 0; k < gais_pkg::N_AXES; k++)
            begin
                sum_reg[k] <= '0;
            end
        end

        if (state_reg == gais_pkg::ST_DIV2)
        begin
            mean_reg[axis_reg] <= mean_next;
        end

        if (state_reg == gais_pkg::ST_DONE && out_free)
        begin
            for (int k = 0; k < gais_pkg::N_AXES; k++)
            begin
                raw_out_reg[k]  <= angle_reg[k];
                mean_out_reg[k] <= mean_reg[k];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign raw_roll   = raw_out_reg[gais_pkg::AXIS_ROLL];
    assign raw_pitch  = raw_out_reg[gais_pkg::AXIS_PITCH];
    assign raw_yaw    = raw_out_reg[gais_pkg::AXIS_YAW];
    assign mean_roll  = mean_out_reg[gais_pkg::AXIS_ROLL];
    assign mean_pitch = mean_out_reg[gais_pkg::AXIS_PITCH];
    assign mean_yaw   = mean_out_reg[gais_pkg::AXIS_YAW];

    // a request is taken only while idle, so ready drops right after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("in_ready still high after a request was taken");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(WINDOW))
        else $error("window fill count beyond window size");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gais_pkg::WIDE_W'(angle_reg[0]) >= -gais_pkg::HALF_TURN)
        && (gais_pkg::WIDE_W'(angle_reg[0]) <= gais_pkg::HALF_TURN)
        && (gais_pkg::WIDE_W'(angle_reg[1]) >= -gais_pkg::HALF_TURN)
        && (gais_pkg::WIDE_W'(angle_reg[1]) <= gais_pkg::HALF_TURN)
        && (gais_pkg::WIDE_W'(angle_reg[2]) >= -gais_pkg::HALF_TURN)
        && (gais_pkg::WIDE_W'(angle_reg[2]) <= gais_pkg::HALF_TURN))
        else $error("angle outside half turn");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gais_pkg::ST_DONE))
        else $error("result raised outside the load step");

endmodule

`default_nettype wire

// File: dv/gyro_angle_checker.sv
module gyro_angle_checker #(
    parameter int WINDOW = 6
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic                                    pready,
    input  logic [gais_pkg::PADDR_W-1:0]            paddr,
    input  logic [gais_pkg::APB_DW-1:0]             pwdata,

    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [gais_pkg::RATE_W-1:0]      rate_roll,
    input  logic signed [gais_pkg::RATE_W-1:0]      rate_pitch,
    input  logic signed [gais_pkg::RATE_W-1:0]      rate_yaw,
    input  logic [gais_pkg::TIME_W-1:0]             time_ms,
    input  logic                                    sample_ok,

    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     raw_roll,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     raw_pitch,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     raw_yaw,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     mean_roll,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     mean_pitch,
    input  logic signed [gais_pkg::ANGLE_W-1:0]     mean_yaw,

    output int                                      mismatch_count,
    output int                                      outstanding
);

    // 180 and 360 degrees in Q9.16
    localparam longint HALF_TURN_Q16 = 64'sd11796480;
    localparam longint FULL_TURN_Q16 = 64'sd23592960;

    typedef logic signed [gais_pkg::ANGLE_W-1:0] angle_t;

    typedef struct packed {
        angle_t raw_r;
        angle_t raw_p;
        angle_t raw_y;
        angle_t avg_r;
        angle_t avg_p;
        angle_t avg_y;
    } angle_report_t;

    logic                           present;
    logic                           started;
    logic [gais_pkg::TIME_W-1:0]    last_ms;
    angle_t                         angle [gais_pkg::N_AXES];
    angle_t                         window [WINDOW][gais_pkg::N_AXES];
    int                             fill;
    int                             slot;
    angle_report_t                  pending_angles [$];

    function automatic angle_t integrate_axis(angle_t ang,
                                              logic signed [gais_pkg::RATE_W-1:0] rate,
                                              logic [gais_pkg::TIME_W-1:0] dt);
        longint inc;
        longint sum;
        begin
            // exact product, then truncation toward zero
            inc = longint'(rate) * longint'(dt) * 4096 / 1000;
            if (inc > FULL_TURN_Q16)
            begin
                inc = FULL_TURN_Q16;
            end
            else if (inc < -FULL_TURN_Q16)
            begin
                inc = -FULL_TURN_Q16;
            end
            sum = longint'(ang) + inc;
            if (sum < -HALF_TURN_Q16)
            begin
                sum = sum + FULL_TURN_Q16;
            end
            else if (sum > HALF_TURN_Q16)
            begin
                sum = sum - FULL_TURN_Q16;
            end
            return sum[gais_pkg::ANGLE_W-1:0];
        end
    endfunction

    function automatic angle_t window_mean(int axis);
        longint total;
        begin
            total = 0;
            for (int i = 0; i < fill; i++)
            begin
                total = total + longint'(window[i][axis]);
            end
            if (fill > 0)
            begin
                total = total / longint'(fill);
            end
            return total[gais_pkg::ANGLE_W-1:0];
        end
    endfunction

    task automatic report_mismatch(string label, angle_t got, angle_t want);
        begin
            $display("mismatch on %s: got %0d, predicted %0d", label, got, want);
            mismatch_count++;
        end
    endtask

    task automatic compare_field(string label, angle_t got, angle_t want);
        begin
            if (got !== want)
            begin
                report_mismatch(label, got, want);
            end
        end
    endtask

    task automatic check_result();
        angle_report_t want;
        begin
            if (pending_angles.size() == 0)
            begin
                report_mismatch("result with no request pending (raw_roll)", raw_roll, '0);
            end
            else
            begin
                want = pending_angles.pop_front();
                compare_field("raw_roll", raw_roll, want.raw_r);
                compare_field("raw_pitch", raw_pitch, want.raw_p);
                compare_field("raw_yaw", raw_yaw, want.raw_y);
                compare_field("mean_roll", mean_roll, want.avg_r);
                compare_field("mean_pitch", mean_pitch, want.avg_p);
                compare_field("mean_yaw", mean_yaw, want.avg_y);
            end
        end
    endtask

    task automatic predict_request();
        logic [gais_pkg::TIME_W-1:0] dt;
        angle_report_t               rep;
        begin
            if (present)
            begin
                if (!started)
                begin
                    // first request only zeroes the angles and latches the timer
                    last_ms = time_ms;
                    for (int k = 0; k < gais_pkg::N_AXES; k++)
                    begin
                        angle[k] = '0;
                    end
                    started = 1'b1;
                end
                else if (sample_ok)
                begin
                    dt = time_ms - last_ms;
                    last_ms = time_ms;
                    angle[gais_pkg::AXIS_ROLL] =
                        integrate_axis(angle[gais_pkg::AXIS_ROLL], rate_roll, dt);
                    angle[gais_pkg::AXIS_PITCH] =
                        integrate_axis(angle[gais_pkg::AXIS_PITCH], rate_pitch, dt);
                    angle[gais_pkg::AXIS_YAW] =
                        integrate_axis(angle[gais_pkg::AXIS_YAW], rate_yaw, dt);
                end
                for (int k = 0; k < gais_pkg::N_AXES; k++)
                begin
                    window[slot][k] = angle[k];
                end
                slot = (slot + 1) % WINDOW;
                if (fill < WINDOW)
                begin
                    fill++;
                end
            end
            rep.raw_r = angle[gais_pkg::AXIS_ROLL];
            rep.raw_p = angle[gais_pkg::AXIS_PITCH];
            rep.raw_y = angle[gais_pkg::AXIS_YAW];
            rep.avg_r = window_mean(gais_pkg::AXIS_ROLL);
            rep.avg_p = window_mean(gais_pkg::AXIS_PITCH);
            rep.avg_y = window_mean(gais_pkg::AXIS_YAW);
            pending_angles.insert(pending_angles.size(), rep);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present = 1'b0;
            started = 1'b0;
            last_ms = '0;
            for (int k = 0; k < gais_pkg::N_AXES; k++)
            begin
                angle[k] = '0;
            end
            fill = 0;
            slot = 0;
            pending_angles.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr == gais_pkg::ADDR_SENSOR_PRESENT)
            begin
                present = pwdata[0];
            end
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                predict_request();
            end
            outstanding = pending_angles.size();
        end
    end

endmodule

// File: dv/testbench.sv
module testbench;

    localparam int WINDOW     = 6;
    localparam int IDLE_LIMIT = 4000;

    logic                                   clk;
    logic                                   rst_n;

    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [gais_pkg::PADDR_W-1:0]           paddr;
    logic [gais_pkg::APB_DW-1:0]            pwdata;
    logic [gais_pkg::APB_DW-1:0]            prdata;
    logic                                   pready;

    logic                                   in_valid;
    logic                                   in_ready;
    logic signed [gais_pkg::RATE_W-1:0]     rate_roll;
    logic signed [gais_pkg::RATE_W-1:0]     rate_pitch;
    logic signed [gais_pkg::RATE_W-1:0]     rate_yaw;
    logic [gais_pkg::TIME_W-1:0]            time_ms;
    logic                                   sample_ok;

    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [gais_pkg::ANGLE_W-1:0]    raw_roll;
    logic signed [gais_pkg::ANGLE_W-1:0]    raw_pitch;
    logic signed [gais_pkg::ANGLE_W-1:0]    raw_yaw;
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_roll;
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_pitch;
    logic signed [gais_pkg::ANGLE_W-1:0]    mean_yaw;

    int                                     mismatch_count;
    int                                     outstanding;
    int                                     idle_cycles = 0;
    int                                     ready_mode = 0;
    int                                     burst_left = 0;
    logic [gais_pkg::TIME_W-1:0]            clock_ms;

    gyro_angle_integrator_smoother #(
        .WINDOW     (WINDOW)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rate_roll  (rate_roll),
        .rate_pitch (rate_pitch),
        .rate_yaw   (rate_yaw),
        .time_ms    (time_ms),
        .sample_ok  (sample_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .raw_roll   (raw_roll),
        .raw_pitch  (raw_pitch),
        .raw_yaw    (raw_yaw),
        .mean_roll  (mean_roll),
        .mean_pitch (mean_pitch),
        .mean_yaw   (mean_yaw)
    );

    gyro_angle_checker #(
        .WINDOW         (WINDOW)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rate_roll      (rate_roll),
        .rate_pitch     (rate_pitch),
        .rate_yaw       (rate_yaw),
        .time_ms        (time_ms),
        .sample_ok      (sample_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .raw_roll       (raw_roll),
        .raw_pitch      (raw_pitch),
        .raw_yaw        (raw_yaw),
        .mean_roll      (mean_roll),
        .mean_pitch     (mean_pitch),
        .mean_yaw       (mean_yaw),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls follow a mode that changes now and then
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
        begin
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ~out_ready;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pwrite && pready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [gais_pkg::PADDR_W-1:0] addr,
                             logic [gais_pkg::APB_DW-1:0] data);
        begin
            psel = 1'b1;
            penable = 1'b0;
            pwrite = 1'b1;
            paddr = addr;
            pwdata = data;
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
            @(negedge clk);
            psel = 1'b0;
            penable = 1'b0;
            pwrite = 1'b0;
        end
    endtask

    task automatic drain_results();
        begin
            in_valid = 1'b0;
            while (outstanding != 0)
            begin
                @(negedge clk);
            end
            repeat (4) @(negedge clk);
        end
    endtask

    // rates are given as integers and keep their low 16 bits
    task automatic send_sample(int r, int p, int y, logic [gais_pkg::TIME_W-1:0] t,
                               logic ok);
        int gap;
        int choice;
        begin
            in_valid = 1'b1;
            rate_roll = gais_pkg::RATE_W'(r);
            rate_pitch = gais_pkg::RATE_W'(p);
            rate_yaw = gais_pkg::RATE_W'(y);
            time_ms = t;
            sample_ok = ok;
            do @(posedge clk); while (!in_ready);
            @(negedge clk);
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                in_valid = 1'b0;
                choice = $urandom_range(0, 9);
                if (choice < 6)
                begin
                    gap = $urandom_range(1, 4);
                end
                else if (choice < 9)
                begin
                    gap = $urandom_range(5, 30);
                end
                else
                begin
                    gap = $urandom_range(31, 60);
                end
                repeat (gap) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
            end
        end
    endtask

    task automatic send_after(logic [gais_pkg::TIME_W-1:0] dt, int r, int p, int y,
                              logic ok);
        begin
            clock_ms = clock_ms + dt;
            send_sample(r, p, y, clock_ms, ok);
        end
    endtask

    task automatic send_random_sample();
        int                             pick;
        logic [gais_pkg::TIME_W-1:0]    dt;
        int                             rr [3];
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                dt = $urandom_range(0, 60);
            end
            else if (pick < 70)
            begin
                dt = $urandom_range(0, 3000);
            end
            else if (pick < 80)
            begin
                dt = $urandom();
            end
            else if (pick < 88)
            begin
                dt = '0;
            end
            else
            begin
                // around the increment saturation point
                dt = $urandom_range(150, 400);
            end
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    rr[k] = int'($urandom_range(0, 400)) - 200;
                end
                else
                begin
                    rr[k] = int'($urandom_range(0, 65535)) - 32768;
                end
            end
            send_after(dt, rr[0], rr[1], rr[2], $urandom_range(0, 6) != 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rate_roll = '0;
        rate_pitch = '0;
        rate_yaw = '0;
        time_ms = '0;
        sample_ok = 1'b0;
        clock_ms = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sensor absent before anything has started: zero angles, empty window
        apb_write(gais_pkg::ADDR_SENSOR_PRESENT, 32'd0);
        repeat (3) send_random_sample();
        drain_results();
        apb_write(gais_pkg::ADDR_SENSOR_PRESENT, 32'd1);

        // first request zeroes even with sample_ok low
        clock_ms = 32'hFFFF_FFC0;
        send_sample(32767, -32768, 1234, clock_ms, 1'b0);
        // timer wraps; roll lands exactly on +180, pitch on -180, yaw just past and wraps
        send_after(100, 28800, -28800, 28801, 1'b1);
        send_after(32, 32767, 32767, 32767, 1'b1);
        send_after(100, -32768, -32768, -32768, 1'b1);
        send_after(50, -32768, 0, 32767, 1'b0);
        send_after(0, 32767, -32768, 100, 1'b1);
        send_after(1, 1, -1, 3, 1'b1);
        send_after(1, -3, 0, -1, 1'b1);
        // increment exactly one full turn, then one step past it
        send_after(200, 28800, -28800, 28801, 1'b1);
        send_after(200, -28801, 28801, -28800, 1'b1);
        send_after(32'hFFFF_FFFF, 1, -1, 0, 1'b1);
        repeat (6) send_after(60, 32767, -32768, 16384, 1'b1);
        send_after(0, 0, 0, 0, 1'b1);
        send_after(500, 0, 0, 0, 1'b0);
        // alternating bit patterns
        send_after(3, 21845, -21846, 21845, 1'b1);
        send_after(3, -21846, 21845, -21846, 1'b1);
        drain_results();

        for (int n = 0; n < 400; n++)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                drain_results();
            end
            send_random_sample();
        end
        drain_results();

        // frozen state: results repeat the current angles and window
        apb_write(gais_pkg::ADDR_SENSOR_PRESENT, 32'd0);
        repeat (30) send_random_sample();
        drain_results();
        apb_write(gais_pkg::ADDR_SENSOR_PRESENT, 32'd1);

        for (int n = 0; n < 400; n++)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                drain_results();
            end
            send_random_sample();
        end
        drain_results();
        repeat (40) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
